[design/apmm_pkg.sv]
// Package for the attitude PD controller and X-quad motor mixer.
// Holds field widths, fixed-point constants, mixer signs and register indexes.
// No dependencies.
`default_nettype none

package apmm_pkg;

    // Field widths
    localparam int ANGLE_W  = 12;
    localparam int TARGET_W = 13;
    localparam int RATE_W   = 24;
    localparam int THR_W    = 10;
    localparam int MV_W     = 13;
    localparam int GAIN_W   = 16;
    localparam int DUTY_W   = 10;
    localparam int DRV_W    = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Fixed-point constants
    localparam int BASE_MV    = 4200;
    localparam int SHUTOFF_MV = 2700;
    localparam int HALF_TURN  = 1800;
    localparam int FULL_TURN  = 3600;
    localparam int RAD_Q16    = 114;     // pi/1800 in Q0.16
    localparam int RATE_Q32   = 42950;   // 1/100000 in Q0.32
    localparam int AMP_FRAC   = 14;      // battery factor is Q1.14
    localparam int DUTY_RESET = 600;

    // Battery factor divider: amp = (BASE_MV << AMP_FRAC) / batt_mv
    localparam int AMP_W = 15;           // quotient bits, one per divider stage
    localparam int DIV_W = 27;           // dividend and remainder width
    localparam logic [DIV_W-1:0] DIV_NUM = DIV_W'(BASE_MV * (1 << AMP_FRAC));

    // Axis indexes
    localparam int AX_YAW   = 0;
    localparam int AX_PITCH = 1;
    localparam int AX_ROLL  = 2;
    localparam int N_AX     = 3;
    localparam int N_MOTOR  = 4;

    // Mixer signs, bit m set means motor m takes the axis negated.
    // Motor order: rear left, front right, rear right, front left.
    localparam logic [N_MOTOR-1:0] MIX_RUD_NEG  = 4'b1100;
    localparam logic [N_MOTOR-1:0] MIX_ELEV_NEG = 4'b0101;
    localparam logic [N_MOTOR-1:0] MIX_AIL_NEG  = 4'b1001;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GAIN_YAW_P   = 3'd0,
        REG_GAIN_YAW_D   = 3'd1,
        REG_GAIN_PITCH_P = 3'd2,
        REG_GAIN_PITCH_D = 3'd3,
        REG_GAIN_ROLL_P  = 3'd4,
        REG_GAIN_ROLL_D  = 3'd5,
        REG_DUTY_LIMIT   = 3'd6,
        REG_TARGET_YAW   = 3'd7
    } t_reg_idx;

endpackage

`default_nettype wire

[design/attitude_pd_motor_mixer_top.sv]
// Attitude PD controller with battery compensation and X-quad motor mixer.
// Depends on apmm_pkg for widths, fixed-point constants and register indexes.
//
//   channel   | handshake                 | payload
//   ----------+---------------------------+--------------------------------------
//   request   | start, busy               | angles, rates, targets, throttle, mv
//   result    | o_valid (one-cycle strobe)| four motor duties, three axis drives
//   config    | i_cfg_valid, o_cfg_ready  | i_cfg_index, i_cfg_data
//
// A request enters every cycle. The pipeline depth is set by the battery-factor
// divider, a restoring divider of 15 stages, one
// quotient bit per stage, running beside the 5-stage PD path (error, two products,
// sum, drive). busy stays low and o_cfg_ready high: nothing in the pipeline waits.
// i_rst_n (synchronous, active low) clears the valid bits and loads the
// register reset values; payload registers are not reset.
`default_nettype none

module attitude_pd_motor_mixer_top (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    // request channel
    input  wire logic                                   start,
    output logic                                        busy,
    input  wire logic signed [apmm_pkg::ANGLE_W-1:0]    i_yaw_angle,
    input  wire logic signed [apmm_pkg::ANGLE_W-1:0]    i_pitch_angle,
    input  wire logic signed [apmm_pkg::ANGLE_W-1:0]    i_roll_angle,
    input  wire logic signed [apmm_pkg::RATE_W-1:0]     i_rate_x,
    input  wire logic signed [apmm_pkg::RATE_W-1:0]     i_rate_y,
    input  wire logic signed [apmm_pkg::RATE_W-1:0]     i_rate_z,
    input  wire logic signed [apmm_pkg::TARGET_W-1:0]   i_target_pitch,
    input  wire logic signed [apmm_pkg::TARGET_W-1:0]   i_target_roll,
    input  wire logic        [apmm_pkg::THR_W-1:0]      i_throttle,
    input  wire logic        [apmm_pkg::MV_W-1:0]       i_batt_mv,
    input  wire logic                                   i_enable,
    // result channel
    output logic                                        o_valid,
    output logic             [apmm_pkg::DUTY_W-1:0]     o_motor_rear_left,
    output logic             [apmm_pkg::DUTY_W-1:0]     o_motor_front_right,
    output logic             [apmm_pkg::DUTY_W-1:0]     o_motor_rear_right,
    output logic             [apmm_pkg::DUTY_W-1:0]     o_motor_front_left,
    output logic signed      [apmm_pkg::DRV_W-1:0]      o_yaw_drive,
    output logic signed      [apmm_pkg::DRV_W-1:0]      o_pitch_drive,
    output logic signed      [apmm_pkg::DRV_W-1:0]      o_roll_drive,
    // configuration channel
    input  wire logic                                   i_cfg_valid,
    output logic                                        o_cfg_ready,
    input  wire logic        [apmm_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic        [apmm_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import apmm_pkg::*;

    // Stage numbers
    localparam int ST_ERR  = 1;        // angle errors registered
    localparam int ST_MUL1 = 2;        // gain products
    localparam int ST_MUL2 = 3;        // fixed-point scale products
    localparam int ST_SUM  = 4;        // P + D sum
    localparam int ST_DRV  = 5;        // truncated, saturated drives
    localparam int ST_DIV  = AMP_W;    // last divider stage
    localparam int ST_PROD = ST_DIV + 1;
    localparam int ST_SCL  = ST_PROD + 1;
    localparam int ST_OUT  = ST_SCL + 1;

    localparam int ERR_W = 14;
    localparam int PM1_W = GAIN_W + ERR_W;
    localparam int PM2_W = PM1_W + 8;
    localparam int DM1_W = GAIN_W + RATE_W;
    localparam int DM2_W = DM1_W + 17;
    localparam int ACC_W = 58;
    localparam int QT_W  = ACC_W - 32;
    localparam int TP_W  = THR_W + AMP_W;
    localparam int AP_W  = DRV_W + AMP_W + 1;
    localparam int T_W   = TP_W - AMP_FRAC;
    localparam int AX_W  = AP_W - AMP_FRAC;
    localparam int MIX_W = 21;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic signed [GAIN_W-1:0]  r_gain_p [N_AX];
    logic signed [GAIN_W-1:0]  r_gain_d [N_AX];
    logic        [DUTY_W-1:0]  r_duty_limit;
    logic signed [ANGLE_W-1:0] r_target_yaw;

    assign o_cfg_ready = 1'b1;
    assign busy        = 1'b0;

    // Load a register on each write request; unknown indexes do not exist
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < N_AX; i++) begin
                r_gain_p[i] <= '0;
                r_gain_d[i] <= '0;
            end
            r_duty_limit <= DUTY_W'(DUTY_RESET);
            r_target_yaw <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_GAIN_YAW_P:   r_gain_p[AX_YAW]   <= i_cfg_data;
                REG_GAIN_YAW_D:   r_gain_d[AX_YAW]   <= i_cfg_data;
                REG_GAIN_PITCH_P: r_gain_p[AX_PITCH] <= i_cfg_data;
                REG_GAIN_PITCH_D: r_gain_d[AX_PITCH] <= i_cfg_data;
                REG_GAIN_ROLL_P:  r_gain_p[AX_ROLL]  <= i_cfg_data;
                REG_GAIN_ROLL_D:  r_gain_d[AX_ROLL]  <= i_cfg_data;
                REG_DUTY_LIMIT:   r_duty_limit       <= i_cfg_data[DUTY_W-1:0];
                REG_TARGET_YAW:   r_target_yaw       <= i_cfg_data[ANGLE_W-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Valid bits and side payload that rides along the pipeline
    // ------------------------------------------------------------------
    logic                     r_vld  [ST_ERR:ST_OUT];
    logic        [THR_W-1:0]  r_thr  [ST_ERR:ST_DIV];
    logic                     r_en   [ST_ERR:ST_PROD];
    logic                     r_lowb [ST_ERR:ST_DIV];
    logic signed [DRV_W-1:0]  r_drv  [ST_DRV:ST_SCL][N_AX];

    // Advance valid bits every cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = ST_ERR; k <= ST_OUT; k++) r_vld[k] <= 1'b0;
        end else begin
            r_vld[ST_ERR] <= start && !busy;
            for (int k = ST_ERR + 1; k <= ST_OUT; k++) r_vld[k] <= r_vld[k-1];
        end
    end

    // Shift throttle, enable and low-battery flag along
    always_ff @(posedge i_clk) begin
        r_thr[ST_ERR]  <= i_throttle;
        r_en[ST_ERR]   <= i_enable;
        r_lowb[ST_ERR] <= i_batt_mv < MV_W'(SHUTOFF_MV);
        for (int k = ST_ERR + 1; k <= ST_DIV; k++) begin
            r_thr[k]  <= r_thr[k-1];
            r_lowb[k] <= r_lowb[k-1];
        end
        for (int k = ST_ERR + 1; k <= ST_PROD; k++) r_en[k] <= r_en[k-1];
    end

    // ------------------------------------------------------------------
    // Stage 1: angle errors with half-turn wrap on yaw and roll
    // ------------------------------------------------------------------
    logic signed [ERR_W-1:0]  n_err [N_AX];
    logic signed [ERR_W-1:0]  n_raw [N_AX];
    logic signed [ERR_W-1:0]  n_wr1 [N_AX];
    logic signed [ERR_W-1:0]  r_err [N_AX];
    logic signed [RATE_W-1:0] r_rate [N_AX];

    always_comb begin
        n_raw[AX_YAW]   = ERR_W'(i_yaw_angle) - ERR_W'(r_target_yaw);
        n_raw[AX_PITCH] = ERR_W'(i_pitch_angle) - ERR_W'(i_target_pitch);
        n_raw[AX_ROLL]  = ERR_W'(i_roll_angle) - ERR_W'(i_target_roll);
        for (int i = 0; i < N_AX; i++) begin
            n_wr1[i] = n_raw[i];
            if (n_raw[i] > ERR_W'(HALF_TURN)) n_wr1[i] = n_raw[i] - ERR_W'(FULL_TURN);
            n_err[i] = n_wr1[i];
            if (n_wr1[i] < -ERR_W'(HALF_TURN)) n_err[i] = n_wr1[i] + ERR_W'(FULL_TURN);
        end
        // pitch is not wrapped
        n_err[AX_PITCH] = n_raw[AX_PITCH];
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < N_AX; i++) r_err[i] <= n_err[i];
        r_rate[AX_YAW]   <= i_rate_z;
        r_rate[AX_PITCH] <= i_rate_y;
        r_rate[AX_ROLL]  <= i_rate_x;
    end

    // ------------------------------------------------------------------
    // Stages 2-4: gain products, fixed-point scaling, P + D sum
    // ------------------------------------------------------------------
    logic signed [PM1_W-1:0] r_pm1 [N_AX];
    logic signed [DM1_W-1:0] r_dm1 [N_AX];
    logic signed [PM2_W-1:0] r_pm2 [N_AX];
    logic signed [DM2_W-1:0] r_dm2 [N_AX];
    logic signed [ACC_W-1:0] r_acc [N_AX];

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < N_AX; i++) begin
            r_pm1[i] <= PM1_W'(r_gain_p[i]) * PM1_W'(r_err[i]);
            r_dm1[i] <= DM1_W'(r_gain_d[i]) * DM1_W'(r_rate[i]);
            r_pm2[i] <= PM2_W'(r_pm1[i]) * PM2_W'(RAD_Q16);
            r_dm2[i] <= DM2_W'(r_dm1[i]) * DM2_W'(RATE_Q32);
            r_acc[i] <= (ACC_W'(r_pm2[i]) <<< 16) + ACC_W'(r_dm2[i]);
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: drop 32 fraction bits toward zero, saturate, gate on throttle
    // ------------------------------------------------------------------
    logic signed [QT_W-1:0]  n_qt  [N_AX];
    logic signed [DRV_W-1:0] n_drv [N_AX];

    always_comb begin
        for (int i = 0; i < N_AX; i++) begin
            n_qt[i] = QT_W'(r_acc[i] >>> 32);
            if (r_acc[i][ACC_W-1] && (r_acc[i][31:0] != '0)) n_qt[i] = n_qt[i] + QT_W'(1);
            if (n_qt[i] > QT_W'(32767))       n_drv[i] = 16'sh7FFF;
            else if (n_qt[i] < -QT_W'(32768)) n_drv[i] = 16'sh8000;
            else                               n_drv[i] = n_qt[i][DRV_W-1:0];
            if (r_thr[ST_SUM] == '0) n_drv[i] = '0;
        end
    end

    // Hold drives alongside the divider
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < N_AX; i++) begin
            r_drv[ST_DRV][i] <= n_drv[i];
            for (int k = ST_DRV + 1; k <= ST_SCL; k++) r_drv[k][i] <= r_drv[k-1][i];
        end
    end

    // ------------------------------------------------------------------
    // Stages 1-15: restoring divider, one quotient bit per stage
    // ------------------------------------------------------------------
    logic [DIV_W-1:0] r_dv_rem [ST_ERR:ST_DIV];
    logic [AMP_W-1:0] r_dv_q   [ST_ERR:ST_DIV];
    logic [MV_W-1:0]  r_dv_mv  [ST_ERR:ST_DIV];
    logic [DIV_W-1:0] n_dv_rem [ST_ERR:ST_DIV];
    logic [AMP_W-1:0] n_dv_q   [ST_ERR:ST_DIV];
    logic [MV_W-1:0]  n_dv_mv  [ST_ERR:ST_DIV];
    logic [DIV_W-1:0] n_dv_try [ST_ERR:ST_DIV];
    logic [DIV_W-1:0] n_dv_pr  [ST_ERR:ST_DIV];

    always_comb begin
        for (int k = ST_ERR; k <= ST_DIV; k++) begin
            if (k == ST_ERR) begin
                n_dv_pr[k] = DIV_NUM;
                n_dv_mv[k] = i_batt_mv;
                n_dv_q[k]  = '0;
            end else begin
                n_dv_pr[k] = r_dv_rem[k-1];
                n_dv_mv[k] = r_dv_mv[k-1];
                n_dv_q[k]  = r_dv_q[k-1];
            end
            n_dv_try[k] = DIV_W'(n_dv_mv[k]) << (AMP_W - k);
            n_dv_rem[k] = n_dv_pr[k];
            if (n_dv_pr[k] >= n_dv_try[k]) begin
                n_dv_rem[k]           = n_dv_pr[k] - n_dv_try[k];
                n_dv_q[k][AMP_W - k]  = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = ST_ERR; k <= ST_DIV; k++) begin
            r_dv_rem[k] <= n_dv_rem[k];
            r_dv_q[k]   <= n_dv_q[k];
            r_dv_mv[k]  <= n_dv_mv[k];
        end
    end

    // ------------------------------------------------------------------
    // Stage 16: scale throttle and drives by the battery factor
    // ------------------------------------------------------------------
    logic        [AMP_W-1:0] n_amp;
    logic signed [AMP_W:0]   n_amp_s;
    logic        [TP_W-1:0]  r_tp;
    logic signed [AP_W-1:0]  r_ap [N_AX];

    assign n_amp   = r_lowb[ST_DIV] ? '0 : r_dv_q[ST_DIV];
    assign n_amp_s = signed'({1'b0, n_amp});

    always_ff @(posedge i_clk) begin
        r_tp <= TP_W'(r_thr[ST_DIV]) * TP_W'(n_amp);
        for (int i = 0; i < N_AX; i++) begin
            r_ap[i] <= AP_W'(r_drv[ST_DIV][i]) * AP_W'(n_amp_s);
        end
    end

    // ------------------------------------------------------------------
    // Stage 17: drop Q1.14 fraction toward zero, zero everything on disable
    // ------------------------------------------------------------------
    logic signed [AX_W-1:0] n_ax [N_AX];
    logic        [T_W-1:0]  r_t;
    logic signed [AX_W-1:0] r_ax [N_AX];

    always_comb begin
        for (int i = 0; i < N_AX; i++) begin
            n_ax[i] = AX_W'(r_ap[i] >>> AMP_FRAC);
            if (r_ap[i][AP_W-1] && (r_ap[i][AMP_FRAC-1:0] != '0)) begin
                n_ax[i] = n_ax[i] + AX_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_t <= r_en[ST_PROD] ? r_tp[TP_W-1:AMP_FRAC] : '0;
        for (int i = 0; i < N_AX; i++) r_ax[i] <= r_en[ST_PROD] ? n_ax[i] : '0;
    end

    // ------------------------------------------------------------------
    // Stage 18: mix onto four motors and clamp to 0..duty_limit
    // ------------------------------------------------------------------
    logic signed [MIX_W-1:0]  n_mix   [N_MOTOR];
    logic        [DUTY_W-1:0] n_motor [N_MOTOR];
    logic        [DUTY_W-1:0] r_motor [N_MOTOR];
    logic signed [DRV_W-1:0]  r_out_drv [N_AX];

    always_comb begin
        for (int m = 0; m < N_MOTOR; m++) begin
            n_mix[m] = MIX_W'(signed'({1'b0, r_t}))
                + (MIX_RUD_NEG[m]  ? -MIX_W'(r_ax[AX_YAW])   : MIX_W'(r_ax[AX_YAW]))
                + (MIX_ELEV_NEG[m] ? -MIX_W'(r_ax[AX_PITCH]) : MIX_W'(r_ax[AX_PITCH]))
                + (MIX_AIL_NEG[m]  ? -MIX_W'(r_ax[AX_ROLL])  : MIX_W'(r_ax[AX_ROLL]));
            if (n_mix[m] < 0) begin
                n_motor[m] = '0;
            end else if (n_mix[m] > MIX_W'(signed'({1'b0, r_duty_limit}))) begin
                n_motor[m] = r_duty_limit;
            end else begin
                n_motor[m] = n_mix[m][DUTY_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int m = 0; m < N_MOTOR; m++) r_motor[m] <= n_motor[m];
        for (int i = 0; i < N_AX; i++) r_out_drv[i] <= r_drv[ST_SCL][i];
    end

    assign o_valid             = r_vld[ST_OUT];
    assign o_motor_rear_left   = r_motor[0];
    assign o_motor_front_right = r_motor[1];
    assign o_motor_rear_right  = r_motor[2];
    assign o_motor_front_left  = r_motor[3];
    assign o_yaw_drive         = r_out_drv[AX_YAW];
    assign o_pitch_drive       = r_out_drv[AX_PITCH];
    assign o_roll_drive        = r_out_drv[AX_ROLL];

endmodule

`default_nettype wire

[tb/apmm_checker.sv]
// Scoreboard for attitude_pd_motor_mixer_top: predicts each request's motor duties
// and axis drives and compares them with the strobed results.
// Depends on apmm_pkg for widths, fixed-point constants, mixer signs and register indexes.
module apmm_checker (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_start,
    input  logic                                  i_busy,
    input  logic signed [apmm_pkg::ANGLE_W-1:0]   i_yaw_angle,
    input  logic signed [apmm_pkg::ANGLE_W-1:0]   i_pitch_angle,
    input  logic signed [apmm_pkg::ANGLE_W-1:0]   i_roll_angle,
    input  logic signed [apmm_pkg::RATE_W-1:0]    i_rate_x,
    input  logic signed [apmm_pkg::RATE_W-1:0]    i_rate_y,
    input  logic signed [apmm_pkg::RATE_W-1:0]    i_rate_z,
    input  logic signed [apmm_pkg::TARGET_W-1:0]  i_target_pitch,
    input  logic signed [apmm_pkg::TARGET_W-1:0]  i_target_roll,
    input  logic        [apmm_pkg::THR_W-1:0]     i_throttle,
    input  logic        [apmm_pkg::MV_W-1:0]      i_batt_mv,
    input  logic                                  i_enable,
    input  logic                                  i_res_valid,
    input  logic        [apmm_pkg::DUTY_W-1:0]    i_motor_rear_left,
    input  logic        [apmm_pkg::DUTY_W-1:0]    i_motor_front_right,
    input  logic        [apmm_pkg::DUTY_W-1:0]    i_motor_rear_right,
    input  logic        [apmm_pkg::DUTY_W-1:0]    i_motor_front_left,
    input  logic signed [apmm_pkg::DRV_W-1:0]     i_yaw_drive,
    input  logic signed [apmm_pkg::DRV_W-1:0]     i_pitch_drive,
    input  logic signed [apmm_pkg::DRV_W-1:0]     i_roll_drive,
    input  logic                                  i_cfg_valid,
    input  logic                                  i_cfg_ready,
    input  logic        [apmm_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic        [apmm_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output int                                    o_mismatches,
    output int                                    o_outstanding,
    output int                                    o_results
);
    timeunit 1ns;
    timeprecision 1ps;
    import apmm_pkg::*;

    localparam longint DRV_MAX = (longint'(1) <<< (DRV_W - 1)) - 1;
    localparam longint DRV_MIN = -DRV_MAX - 1;

    typedef struct {
        logic [N_MOTOR-1:0][DUTY_W-1:0] motor;
        logic [DRV_W-1:0]               yaw;
        logic [DRV_W-1:0]               pitch;
        logic [DRV_W-1:0]               roll;
    } t_mixer_out;

    string motor_label [N_MOTOR] = '{"motor_rear_left", "motor_front_right",
                                     "motor_rear_right", "motor_front_left"};

    // shadow copy of the register file
    longint kp_yaw, kd_yaw, kp_pitch, kd_pitch, kp_roll, kd_roll;
    longint duty_cap, yaw_setpoint;

    t_mixer_out duty_backlog [$];

    // wrap an angle error into one half turn either way, once
    function automatic longint fold_half_turn(longint err);
        if (err > HALF_TURN)
            err -= FULL_TURN;
        if (err < -HALF_TURN)
            err += FULL_TURN;
        return err;
    endfunction

    // PD sum in Q32, truncated toward zero, then saturated to the drive width
    function automatic longint axis_drive(longint err, longint rate, longint kp, longint kd);
        longint acc;
        longint v;
        acc = kp * err * RAD_Q16 * 65536 + kd * rate * RATE_Q32;
        v = acc / (longint'(1) <<< 32);
        if (v > DRV_MAX)
            v = DRV_MAX;
        if (v < DRV_MIN)
            v = DRV_MIN;
        return v;
    endfunction

    function automatic longint batt_scale(longint v, longint amp);
        return v * amp / (longint'(1) <<< AMP_FRAC);
    endfunction

    // expected duties and drives for the request now on the input ports
    function automatic t_mixer_out mix_request();
        t_mixer_out res;
        longint     ydrv, pdrv, rdrv, amp, t, r, e, a, y;
        ydrv = 0;
        pdrv = 0;
        rdrv = 0;
        if (i_throttle != 0) begin
            ydrv = axis_drive(fold_half_turn(longint'(i_yaw_angle) - yaw_setpoint),
                              longint'(i_rate_z), kp_yaw, kd_yaw);
            pdrv = axis_drive(longint'(i_pitch_angle) - longint'(i_target_pitch),
                              longint'(i_rate_y), kp_pitch, kd_pitch);
            rdrv = axis_drive(fold_half_turn(longint'(i_roll_angle) - longint'(i_target_roll)),
                              longint'(i_rate_x), kp_roll, kd_roll);
        end
        if (longint'(i_batt_mv) < SHUTOFF_MV)
            amp = 0;
        else
            amp = (longint'(BASE_MV) <<< AMP_FRAC) / longint'(i_batt_mv);
        if (i_enable) begin
            t = batt_scale(longint'(i_throttle), amp);
            r = batt_scale(ydrv, amp);
            e = batt_scale(pdrv, amp);
            a = batt_scale(rdrv, amp);
        end else begin
            t = 0;
            r = 0;
            e = 0;
            a = 0;
        end
        // mix onto the four motors and clamp each to 0..duty_cap
        for (int m = 0; m < N_MOTOR; m++) begin
            y = t + (MIX_RUD_NEG[m] ? -r : r) + (MIX_ELEV_NEG[m] ? -e : e)
                  + (MIX_AIL_NEG[m] ? -a : a);
            if (y > duty_cap)
                y = duty_cap;
            if (y < 0)
                y = 0;
            res.motor[m] = y[DUTY_W-1:0];
        end
        res.yaw   = ydrv[DRV_W-1:0];
        res.pitch = pdrv[DRV_W-1:0];
        res.roll  = rdrv[DRV_W-1:0];
        return res;
    endfunction

    task automatic check_field(input string field, input longint want, input longint got);
        if (want != got) begin
            o_mismatches++;
            $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
        end
    endtask

    // track writes, queue predictions, compare results
    always @(posedge i_clk) begin
        t_mixer_out                     want;
        logic [N_MOTOR-1:0][DUTY_W-1:0] seen;
        if (!i_rst_n) begin
            kp_yaw       = 0;
            kd_yaw       = 0;
            kp_pitch     = 0;
            kd_pitch     = 0;
            kp_roll      = 0;
            kd_roll      = 0;
            duty_cap     = DUTY_RESET;
            yaw_setpoint = 0;
            duty_backlog.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (t_reg_idx'(i_cfg_index))
                    REG_GAIN_YAW_P:   kp_yaw   = longint'($signed(i_cfg_data));
                    REG_GAIN_YAW_D:   kd_yaw   = longint'($signed(i_cfg_data));
                    REG_GAIN_PITCH_P: kp_pitch = longint'($signed(i_cfg_data));
                    REG_GAIN_PITCH_D: kd_pitch = longint'($signed(i_cfg_data));
                    REG_GAIN_ROLL_P:  kp_roll  = longint'($signed(i_cfg_data));
                    REG_GAIN_ROLL_D:  kd_roll  = longint'($signed(i_cfg_data));
                    REG_DUTY_LIMIT:   duty_cap = longint'(i_cfg_data[DUTY_W-1:0]);
                    REG_TARGET_YAW:
                        yaw_setpoint = longint'($signed(i_cfg_data[ANGLE_W-1:0]));
                    default: ;
                endcase
            end
            if (i_res_valid) begin
                o_results++;
                if (duty_backlog.size() == 0) begin
                    o_mismatches++;
                    $display("%0t: result with no request outstanding", $time);
                end else begin
                    want = duty_backlog.pop_front();
                    seen = {i_motor_front_left, i_motor_rear_right,
                            i_motor_front_right, i_motor_rear_left};
                    for (int m = 0; m < N_MOTOR; m++)
                        check_field(motor_label[m], longint'(want.motor[m]),
                                    longint'(seen[m]));
                    check_field("yaw_drive", longint'($signed(want.yaw)),
                                longint'(i_yaw_drive));
                    check_field("pitch_drive", longint'($signed(want.pitch)),
                                longint'(i_pitch_drive));
                    check_field("roll_drive", longint'($signed(want.roll)),
                                longint'(i_roll_drive));
                end
            end
            if (i_start && !i_busy)
                duty_backlog.push_back(mix_request());
        end
        o_outstanding <= duty_backlog.size();
    end

endmodule

[tb/attitude_pd_motor_mixer_top_tb.sv]
// Stimulus and verdict for attitude_pd_motor_mixer_top: directed corner requests,
// then random flight data under several gain settings and sender idle rates.
// Depends on apmm_pkg, attitude_pd_motor_mixer_top and apmm_checker.
module attitude_pd_motor_mixer_top_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import apmm_pkg::*;

    localparam int N_REGS         = 8;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASE_ITEMS    = 95;
    localparam int SETTLE_CYCLES  = 40;

    typedef enum int {PROF_MODERATE, PROF_MAX, PROF_MIN, PROF_WILD} t_gain_prof;

    typedef struct {
        logic signed [ANGLE_W-1:0]  yaw, pitch, roll;
        logic signed [RATE_W-1:0]   rate_x, rate_y, rate_z;
        logic signed [TARGET_W-1:0] tgt_pitch, tgt_roll;
        logic        [THR_W-1:0]    throttle;
        logic        [MV_W-1:0]     batt_mv;
        logic                       enable;
    } t_attitude_req;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          start = 1'b0;
    logic                          busy;
    logic signed [ANGLE_W-1:0]     i_yaw_angle = '0;
    logic signed [ANGLE_W-1:0]     i_pitch_angle = '0;
    logic signed [ANGLE_W-1:0]     i_roll_angle = '0;
    logic signed [RATE_W-1:0]      i_rate_x = '0;
    logic signed [RATE_W-1:0]      i_rate_y = '0;
    logic signed [RATE_W-1:0]      i_rate_z = '0;
    logic signed [TARGET_W-1:0]    i_target_pitch = '0;
    logic signed [TARGET_W-1:0]    i_target_roll = '0;
    logic        [THR_W-1:0]       i_throttle = '0;
    logic        [MV_W-1:0]        i_batt_mv = '0;
    logic                          i_enable = 1'b0;
    logic                          o_valid;
    logic        [DUTY_W-1:0]      o_motor_rear_left, o_motor_front_right;
    logic        [DUTY_W-1:0]      o_motor_rear_right, o_motor_front_left;
    logic signed [DRV_W-1:0]       o_yaw_drive, o_pitch_drive, o_roll_drive;
    logic                          i_cfg_valid = 1'b0;
    logic                          o_cfg_ready;
    logic        [CFG_IDX_W-1:0]   i_cfg_index = '0;
    logic        [CFG_DATA_W-1:0]  i_cfg_data = '0;

    int mismatches, outstanding, results;
    int n_requests = 0;
    int n_settings = 0;
    int idle_run = 0;

    logic [CFG_DATA_W-1:0] reg_image [N_REGS];

    always #1 i_clk = ~i_clk;

    attitude_pd_motor_mixer_top dut (
        .i_clk, .i_rst_n, .start, .busy,
        .i_yaw_angle, .i_pitch_angle, .i_roll_angle,
        .i_rate_x, .i_rate_y, .i_rate_z,
        .i_target_pitch, .i_target_roll, .i_throttle, .i_batt_mv, .i_enable,
        .o_valid,
        .o_motor_rear_left, .o_motor_front_right, .o_motor_rear_right, .o_motor_front_left,
        .o_yaw_drive, .o_pitch_drive, .o_roll_drive,
        .i_cfg_valid, .o_cfg_ready, .i_cfg_index, .i_cfg_data
    );

    apmm_checker scoreboard (
        .i_clk, .i_rst_n, .i_start(start), .i_busy(busy),
        .i_yaw_angle, .i_pitch_angle, .i_roll_angle,
        .i_rate_x, .i_rate_y, .i_rate_z,
        .i_target_pitch, .i_target_roll, .i_throttle, .i_batt_mv, .i_enable,
        .i_res_valid(o_valid),
        .i_motor_rear_left(o_motor_rear_left), .i_motor_front_right(o_motor_front_right),
        .i_motor_rear_right(o_motor_rear_right), .i_motor_front_left(o_motor_front_left),
        .i_yaw_drive(o_yaw_drive), .i_pitch_drive(o_pitch_drive),
        .i_roll_drive(o_roll_drive),
        .i_cfg_valid, .i_cfg_ready(o_cfg_ready), .i_cfg_index, .i_cfg_data,
        .o_mismatches(mismatches), .o_outstanding(outstanding), .o_results(results)
    );

    // end the run when no request, result or write moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid || (i_cfg_valid && o_cfg_ready))
            idle_run <= 0;
        else if (idle_run + 1 >= WATCHDOG_LIMIT) begin
            $display("attitude_pd_motor_mixer_top: mismatch");
            $finish;
        end else
            idle_run <= idle_run + 1;
    end

    function automatic t_attitude_req make_req(int yaw, int pitch, int roll,
                                               int rx, int ry, int rz, int tp, int tr,
                                               int thr, int mv, int en);
        t_attitude_req r;
        r.yaw       = ANGLE_W'(yaw);
        r.pitch     = ANGLE_W'(pitch);
        r.roll      = ANGLE_W'(roll);
        r.rate_x    = RATE_W'(rx);
        r.rate_y    = RATE_W'(ry);
        r.rate_z    = RATE_W'(rz);
        r.tgt_pitch = TARGET_W'(tp);
        r.tgt_roll  = TARGET_W'(tr);
        r.throttle  = THR_W'(thr);
        r.batt_mv   = MV_W'(mv);
        r.enable    = en[0];
        return r;
    endfunction

    // mostly in the flight range, sometimes any 12-bit value
    function automatic int rand_angle();
        if ($urandom_range(9) == 0)
            return int'($urandom);
        return int'($urandom_range(3600)) - 1800;
    endfunction

    function automatic int rand_target();
        case ($urandom_range(9))
            0:       return int'($urandom);
            1, 2:    return int'($urandom_range(7200)) - 3600;
            default: return int'($urandom_range(3600)) - 1800;
        endcase
    endfunction

    // small rates keep the drives in range, full-scale ones saturate them
    function automatic int rand_rate();
        case ($urandom_range(3))
            0:       return int'($urandom);
            1:       return int'($urandom_range(4000000)) - 2000000;
            default: return int'($urandom_range(400000)) - 200000;
        endcase
    endfunction

    function automatic t_attitude_req rand_req();
        int thr, mv;
        case ($urandom_range(9))
            0:       thr = 0;
            1:       thr = (1 << THR_W) - 1;
            default: thr = int'($urandom_range((1 << THR_W) - 1));
        endcase
        case ($urandom_range(19))
            0, 1, 2: mv = int'($urandom_range(SHUTOFF_MV - 1));
            3:       mv = SHUTOFF_MV - 1 + int'($urandom_range(1));
            4:       mv = int'($urandom);
            default: mv = int'($urandom_range((1 << MV_W) - 1, SHUTOFF_MV));
        endcase
        return make_req(rand_angle(), rand_angle(), rand_angle(),
                        rand_rate(), rand_rate(), rand_rate(),
                        rand_target(), rand_target(), thr, mv,
                        ($urandom_range(9) != 0) ? 1 : 0);
    endfunction

    // fill the register image for one gain setting
    function automatic void pick_profile(t_gain_prof prof);
        case (prof)
            PROF_MAX: begin
                for (int k = 0; k < N_REGS; k++)
                    reg_image[k] = CFG_DATA_W'(16'h7FFF);
                reg_image[REG_DUTY_LIMIT] = CFG_DATA_W'((1 << DUTY_W) - 1);
                reg_image[REG_TARGET_YAW] = CFG_DATA_W'((1 << (ANGLE_W - 1)) - 1);
            end
            PROF_MIN: begin
                for (int k = 0; k < N_REGS; k++)
                    reg_image[k] = CFG_DATA_W'(16'h8000);
                reg_image[REG_DUTY_LIMIT] = '0;
                reg_image[REG_TARGET_YAW] = CFG_DATA_W'(-(1 << (ANGLE_W - 1)));
            end
            PROF_WILD: begin
                for (int k = 0; k < N_REGS; k++)
                    reg_image[k] = CFG_DATA_W'($urandom);
            end
            default: begin
                for (int k = 0; k < N_REGS; k++)
                    reg_image[k] = CFG_DATA_W'(int'($urandom_range(4000)) - 2000);
                reg_image[REG_DUTY_LIMIT] = CFG_DATA_W'($urandom_range(1023, 300));
                reg_image[REG_TARGET_YAW] = CFG_DATA_W'(int'($urandom_range(3600)) - 1800);
            end
        endcase
    endfunction

    // write every register from the image; valid drops only after the last one
    task automatic program_regs();
        for (int k = 0; k < N_REGS; k++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= t_reg_idx'(k);
            i_cfg_data  <= reg_image[k];
            do @(posedge i_clk); while (!o_cfg_ready);
        end
        i_cfg_valid <= 1'b0;
        n_settings++;
    endtask

    // hold start low until every queued result has come back
    task automatic drain();
        start <= 1'b0;
        do @(posedge i_clk); while (outstanding != 0);
    endtask

    // idle at random, then present one request and hold it until accepted
    task automatic send_request(input t_attitude_req r, input int idle_pct);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start          <= 1'b1;
        i_yaw_angle    <= r.yaw;
        i_pitch_angle  <= r.pitch;
        i_roll_angle   <= r.roll;
        i_rate_x       <= r.rate_x;
        i_rate_y       <= r.rate_y;
        i_rate_z       <= r.rate_z;
        i_target_pitch <= r.tgt_pitch;
        i_target_roll  <= r.tgt_roll;
        i_throttle     <= r.throttle;
        i_batt_mv      <= r.batt_mv;
        i_enable       <= r.enable;
        do @(posedge i_clk); while (busy);
        n_requests++;
    endtask

    initial begin
        t_gain_prof plan [7] = '{PROF_MODERATE, PROF_MAX, PROF_MODERATE, PROF_MIN,
                                 PROF_WILD, PROF_MODERATE, PROF_WILD};
        int         idle_plan [3] = '{0, 76, 19};

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // a few requests with the register reset values
        for (int n = 0; n < 8; n++)
            send_request(rand_req(), 0);
        drain();

        // directed corners with fixed gains and the yaw target at minus a half turn
        reg_image[REG_GAIN_YAW_P]   = CFG_DATA_W'(3000);
        reg_image[REG_GAIN_YAW_D]   = CFG_DATA_W'(500);
        reg_image[REG_GAIN_PITCH_P] = CFG_DATA_W'(-2500);
        reg_image[REG_GAIN_PITCH_D] = CFG_DATA_W'(700);
        reg_image[REG_GAIN_ROLL_P]  = CFG_DATA_W'(2000);
        reg_image[REG_GAIN_ROLL_D]  = CFG_DATA_W'(-400);
        reg_image[REG_DUTY_LIMIT]   = CFG_DATA_W'((1 << DUTY_W) - 1);
        reg_image[REG_TARGET_YAW]   = CFG_DATA_W'(-HALF_TURN);
        program_regs();
        send_request(make_req(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 0);
        // yaw error exactly a half turn, then wrapped from above
        send_request(make_req(0, 0, 0, 0, 0, 0, 0, 0, 500, 4200, 1), 0);
        send_request(make_req(2047, 0, 0, 0, 0, 0, 0, 0, 500, 4200, 1), 0);
        send_request(make_req(-2048, 0, 0, 0, 0, 0, 0, 0, 500, 4200, 1), 0);
        // pitch error left unwrapped at both extremes
        send_request(make_req(0, 2047, 0, 0, 0, 0, -4096, 0, 500, 4200, 1), 0);
        send_request(make_req(0, -2048, 0, 0, 0, 0, 4095, 0, 500, 4200, 1), 0);
        // roll wraps from above and below, and only once at the extremes
        send_request(make_req(0, 0, 1700, 0, 0, 0, 0, -1700, 500, 4200, 1), 0);
        send_request(make_req(0, 0, -1700, 0, 0, 0, 0, 1700, 500, 4200, 1), 0);
        send_request(make_req(0, 0, 2047, 0, 0, 0, 0, -4096, 500, 4200, 1), 0);
        send_request(make_req(0, 0, -2048, 0, 0, 0, 0, 4095, 500, 4200, 1), 0);
        // full-scale rates saturate the drives
        send_request(make_req(0, 0, 0, 8388607, -8388608, 8388607, 0, 0, 1023, 2700, 1), 0);
        send_request(make_req(0, 0, 0, -8388608, 8388607, -8388608, 0, 0, 1, 8191, 1), 0);
        // zero throttle kills the feedback
        send_request(make_req(2047, 2047, 2047, 8388607, 0, 0, 0, 0, 0, 4200, 1), 0);
        // enable low: motors off, drives still reported
        send_request(make_req(300, -300, 500, 1000, -1000, 1000, 100, -100, 800, 4200, 0), 0);
        // battery shutoff edge, dead battery, full battery
        send_request(make_req(300, -300, 500, 1000, -1000, 1000, 100, -100, 800, 2699, 1), 0);
        send_request(make_req(300, -300, 500, 1000, -1000, 1000, 100, -100, 800, 0, 1), 0);
        send_request(make_req(300, -300, 500, 1000, -1000, 1000, 100, -100, 1023, 8191, 1), 0);
        send_request(make_req(0, 0, 0, 0, 0, 0, 0, 0, 1023, 2700, 1), 0);
        drain();

        // yaw target at plus a half turn: wrap from below and the lower boundary
        reg_image[REG_TARGET_YAW] = CFG_DATA_W'(HALF_TURN);
        program_regs();
        send_request(make_req(-1800, 0, 0, 0, 0, 0, 0, 0, 500, 4200, 1), 0);
        send_request(make_req(-2048, 0, 0, 0, 0, 0, 0, 0, 500, 4200, 1), 0);
        send_request(make_req(0, 0, 0, 0, 0, 0, 0, 0, 500, 4200, 1), 0);
        send_request(make_req(2047, 0, 0, 0, 0, 0, 0, 0, 500, 4200, 1), 0);
        drain();

        // random flight data, a new gain setting and idle rate per phase
        for (int p = 0; p < $size(plan); p++) begin
            pick_profile(plan[p]);
            program_regs();
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_request(rand_req(), idle_plan[p % 3]);
            drain();
        end

        repeat (SETTLE_CYCLES) @(posedge i_clk);
        $display("Sent %0d requests across %0d register settings; %0d results compared.",
                 n_requests, n_settings, results);
        $display("Covered angle wrap, zero throttle, enable low, battery cutoff, clamping.");
        if (mismatches == 0 && outstanding == 0)
            $display("attitude_pd_motor_mixer_top: match");
        else
            $display("attitude_pd_motor_mixer_top: mismatch");
        $finish;
    end

endmodule

[attitude_pd_motor_mixer_top.f]
design/apmm_pkg.sv
design/attitude_pd_motor_mixer_top.sv
tb/apmm_checker.sv
tb/attitude_pd_motor_mixer_top_tb.sv
